### hdl/lpbp_pkg.sv
// shared types and constants for the lru page buffer pool
package lpbp_pkg;
   localparam int Frames = 16;
   localparam int FrameW = $clog2(Frames);
   localparam int CountW = $clog2(Frames + 1);
   localparam int TableW = 10;
   localparam int PageW = 32;
   localparam int MaxRes = 16;
   localparam int ResCntW = $clog2(MaxRes + 1);

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_MARK  = 2'd2;
   localparam logic [1:0] FUNC_FLUSH = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EMIT,
      ST_FLUSH,
      ST_FEMIT,
      ST_FNONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic flush_step;
      logic none_emit;
   } cmd_type;

   typedef struct packed {
      logic               flush_match;
      logic               flush_more;
      logic               flush_done;
      logic [FrameW-1:0]  flush_idx;
   } status_type;

   typedef struct packed {
      logic [3:0]        frame;
      logic              hit;
      logic              fetch;
      logic              writeback;
      logic [TableW-1:0] victim_table;
      logic [PageW-1:0]  victim_page;
      logic              found;
   } result_type;
endpackage

### hdl/lru_page_buffer_pool_top.sv
// top level of the lru page buffer pool tag controller
// channels: req_ carries one command per transfer (func, table, page);
//   rsp_ carries result transfers, rsp_tlast marks the final one of a command
// read, write and mark dirty: one result; the command passes through the look and
//   emit states to rsp_tvalid, next req accepted the cycle after the rsp transfer
// flush: walks frames by index, one frame per cycle, and stops at each
//   matching frame to present its result, the walk ending at the last matching
//   frame
// a flush with no match walks all 16 frames and yields one result with found clear
// last is set from a look-ahead over the frames not yet walked
// reset clears all frames, marks them free and returns the controller to idle
// when the receiver stalls, the result holds and nothing new is accepted
module lru_page_buffer_pool_top
   import lpbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // func[1:0], table_id[11:2], page_number[43:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // frame, hit, fetch, writeback, victim_table, victim_page
   output logic        rsp_tuser,  // found
   output logic        rsp_tlast
);
   cmd_type    cmd;
   status_type status;
   result_type res;
   logic       last_raw;

   lpbp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .func (req_tdata[1:0]), .status, .cmd,
      .out_valid (rsp_tvalid), .out_last (last_raw), .out_ready (rsp_tready)
   );

   lpbp_datapath u_dp (
      .clock, .reset, .cmd,
      .func (req_tdata[1:0]), .table_num (req_tdata[11:2]),
      .page_number (req_tdata[43:12]), .status, .result (res)
   );

   assign rsp_tdata = {7'b0, res.victim_page, res.victim_table, res.writeback,
                       res.fetch, res.hit, res.frame};
   assign rsp_tuser = res.found;
   assign rsp_tlast = last_raw;
endmodule

### hdl/lpbp_datapath.sv
// tag store, recency ranks, free stack and result forming
module lpbp_datapath
   import lpbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [1:0]        func,
   input  logic [TableW-1:0] table_num,
   input  logic [PageW-1:0]  page_number,
   output status_type        status,
   output result_type        result
);
   logic [Frames-1:0] valid_ff, valid_in, dirty_ff, dirty_in;
   logic [TableW-1:0] tag_t_ff [Frames];
   logic [TableW-1:0] tag_t_in [Frames];
   logic [PageW-1:0]  tag_p_ff [Frames];
   logic [PageW-1:0]  tag_p_in [Frames];
   logic [FrameW-1:0] rank_ff [Frames];
   logic [FrameW-1:0] rank_in [Frames];
   logic [FrameW-1:0] free_ff [Frames];
   logic [FrameW-1:0] free_in [Frames];
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [1:0]        func_ff;
   logic [TableW-1:0] t_ff;
   logic [PageW-1:0]  p_ff;
   logic [FrameW-1:0] idx_ff, idx_in;
   logic [Frames-1:0] match_ff, match_in;
   logic [Frames-1:0] lru_ff, lru_in;
   result_type        res_ff, res_in;

   always_comb begin
      for (int i = 0; i < Frames; i++) begin
         match_in[i] = valid_ff[i] && tag_t_ff[i] == table_num && tag_p_ff[i] == page_number;
         lru_in[i] = rank_ff[i] == FrameW'(Frames - 1);
      end
   end

   logic              hit_any;
   logic [FrameW-1:0] hit_f, lru_f, sel_f;
   logic [FrameW-1:0] old_rank;
   logic              use_free;
   always_comb begin
      hit_any = |match_ff;
      hit_f = '0;
      lru_f = '0;
      for (int i = Frames - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_f = FrameW'(i);
         if (lru_ff[i]) lru_f = FrameW'(i);
      end
      use_free = cnt_ff != '0;
      if (hit_any) sel_f = hit_f;
      else if (use_free) sel_f = free_ff[cnt_ff[FrameW-1:0] - 1'b1];
      else sel_f = lru_f;
      old_rank = rank_ff[sel_f];
   end

   logic fmatch;
   logic fmore;
   assign fmatch = valid_ff[idx_ff] && tag_t_ff[idx_ff] == t_ff;

   // any frame of the table above the current walk index
   always_comb begin
      fmore = 1'b0;
      for (int i = 0; i < Frames; i++)
         if (FrameW'(i) > idx_ff && valid_ff[i] && tag_t_ff[i] == t_ff) fmore = 1'b1;
   end

   assign status.flush_match = fmatch;
   assign status.flush_more = fmore;
   assign status.flush_done = idx_ff == FrameW'(Frames - 1);
   assign status.flush_idx = idx_ff;

   always_comb begin
      logic rw, was_valid;
      logic [FrameW-1:0] fr;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      tag_t_in = tag_t_ff;
      tag_p_in = tag_p_ff;
      rank_in = rank_ff;
      free_in = free_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      res_in = res_ff;
      rw = func_ff == FUNC_READ || func_ff == FUNC_WRITE;
      was_valid = hit_any || !use_free;
      fr = idx_ff;
      if (cmd.capture) idx_in = '0;
      if (cmd.apply) begin
         res_in = '0;
         if (rw) begin
            for (int i = 0; i < Frames; i++)
               if (FrameW'(i) != sel_f && valid_ff[i] && (!was_valid || rank_ff[i] < old_rank))
                  rank_in[i] = rank_ff[i] + 1'b1;
            rank_in[sel_f] = '0;
            res_in.frame = 4'(sel_f);
            if (hit_any) begin
               res_in.hit = 1'b1;
               if (func_ff == FUNC_WRITE) dirty_in[sel_f] = 1'b1;
            end else begin
               if (use_free) cnt_in = cnt_ff - 1'b1;
               res_in.fetch = func_ff == FUNC_READ;
               res_in.writeback = !use_free && dirty_ff[sel_f];
               if (!use_free && dirty_ff[sel_f]) begin
                  res_in.victim_table = tag_t_ff[sel_f];
                  res_in.victim_page = tag_p_ff[sel_f];
               end
               valid_in[sel_f] = 1'b1;
               tag_t_in[sel_f] = t_ff;
               tag_p_in[sel_f] = p_ff;
               dirty_in[sel_f] = func_ff == FUNC_WRITE;
            end
         end else if (hit_any) begin
            dirty_in[sel_f] = 1'b1;
            res_in.frame = 4'(sel_f);
            res_in.hit = 1'b1;
            res_in.found = 1'b1;
         end
      end
      if (cmd.flush_step) begin
         if (fmatch) begin
            res_in = '0;
            res_in.frame = 4'(fr);
            res_in.hit = 1'b1;
            res_in.found = 1'b1;
            res_in.writeback = dirty_ff[fr];
            if (dirty_ff[fr]) begin
               res_in.victim_table = tag_t_ff[fr];
               res_in.victim_page = tag_p_ff[fr];
            end
            valid_in[fr] = 1'b0;
            dirty_in[fr] = 1'b0;
            rank_in[fr] = '0;
            for (int j = 0; j < Frames; j++)
               if (valid_ff[j] && rank_ff[j] > rank_ff[fr]) rank_in[j] = rank_ff[j] - 1'b1;
            if (cnt_ff < CountW'(Frames)) begin
               free_in[cnt_ff[FrameW-1:0]] = fr;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.none_emit) res_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         cnt_ff <= CountW'(Frames);
         for (int i = 0; i < Frames; i++) begin
            rank_ff[i] <= '0;
            free_ff[i] <= FrameW'(i);
         end
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         cnt_ff <= cnt_in;
         rank_ff <= rank_in;
         free_ff <= free_in;
      end
      tag_t_ff <= tag_t_in;
      tag_p_ff <= tag_p_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      match_ff <= match_in;
      lru_ff <= lru_in;
      if (cmd.capture) begin
         func_ff <= func;
         t_ff <= table_num;
         p_ff <= page_number;
      end
   end

   assign result = res_ff;
endmodule

### hdl/lpbp_ctrl.sv
// controller state machine for the buffer pool
module lpbp_ctrl
   import lpbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] func,
   input  status_type status,
   output cmd_type    cmd,
   output logic       out_valid,
   output logic       out_last,
   input  logic       out_ready
);
   state_type state_ff, state_in;
   logic found_ff, found_in, last_ff, last_in;
   logic [ResCntW-1:0] n_ff, n_in;

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      last_in = last_ff;
      n_in = n_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) begin
            state_in = func == FUNC_FLUSH ? ST_FLUSH : ST_LOOK;
            found_in = 1'b0;
            n_in = '0;
         end
         ST_LOOK: state_in = ST_EMIT;
         ST_EMIT: if (out_ready) state_in = ST_IDLE;
         ST_FLUSH: begin
            if (status.flush_match) found_in = 1'b1;
            if (status.flush_match && n_ff < ResCntW'(MaxRes)) begin
               state_in = ST_FEMIT;
               n_in = n_ff + 1'b1;
               last_in = !status.flush_more;
            end else if (status.flush_done)
               state_in = (found_ff || status.flush_match) ? ST_IDLE : ST_FNONE;
         end
         ST_FEMIT: if (out_ready) state_in = last_ff ? ST_IDLE : ST_FLUSH;
         ST_FNONE: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // output decode; last flush report from look-ahead over frames left
   always_comb begin
      cmd = '0;
      in_ready = state_ff == ST_IDLE;
      out_valid = 1'b0;
      out_last = 1'b1;
      case (state_ff)
         ST_IDLE: cmd.capture = in_valid;
         ST_LOOK: cmd.apply = 1'b1;
         ST_EMIT: out_valid = 1'b1;
         ST_FLUSH: begin
            cmd.flush_step = 1'b1;
            cmd.none_emit = status.flush_done && !status.flush_match && !found_ff;
         end
         ST_FEMIT: begin
            out_valid = 1'b1;
            out_last = last_ff;
         end
         ST_FNONE: out_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
         last_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         last_ff <= last_in;
         n_ff <= n_in;
      end
   end
endmodule

### hdl/lpbp_checker.sv
// port-level checks for the buffer pool
module lpbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("req taken while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_fetch_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[4] && rsp_tdata[5])) else $error("fetch on hit");
   a_wb_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[5]) else $error("fetch with found");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast) else $error("lone result without last");
endmodule

bind lru_page_buffer_pool_top lpbp_checker u_chk (.*);
